// ===== rtl/fer_pkg.sv =====
// Shared codes, reset values and payload types of the frame echo recorder.
package fer_pkg;

	// request function codes
	localparam logic [2:0] FUNC_WRITE = 3'd0;
	localparam logic [2:0] FUNC_END   = 3'd1;
	localparam logic [2:0] FUNC_CLEAR = 3'd2;
	localparam logic [2:0] FUNC_TICK  = 3'd3;
	localparam logic [2:0] FUNC_READ  = 3'd4;

	// result kind codes
	localparam logic [2:0] KIND_NONE   = 3'd0;
	localparam logic [2:0] KIND_DATA   = 3'd1;
	localparam logic [2:0] KIND_END    = 3'd2;
	localparam logic [2:0] KIND_STORED = 3'd3;
	localparam logic [2:0] KIND_REJECT = 3'd4;

	// echo mode codes
	localparam logic [1:0] MODE_IDLE = 2'd0;
	localparam logic [1:0] MODE_REC  = 2'd1;
	localparam logic [1:0] MODE_WAIT = 2'd2;
	localparam logic [1:0] MODE_PLAY = 2'd3;

	// configuration register indexes
	localparam logic [1:0] REG_CAPACITY = 2'd0;
	localparam logic [1:0] REG_DELAY    = 2'd1;
	localparam logic [1:0] REG_PERIOD   = 2'd2;

	// configuration reset values
	localparam logic [9:0]  CAPACITY_RST = 10'd512;
	localparam logic [15:0] DELAY_RST    = 16'd2000;
	localparam logic [7:0]  PERIOD_RST   = 8'd40;

	typedef struct packed {
		logic [2:0]  func;
		logic [7:0]  data_byte;
		logic [15:0] tick_ms;
	} req_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] out_byte;
		logic       last;
		logic [1:0] mode;
	} result_t;

endpackage

// ===== rtl/fer_store.sv =====
// Frame byte memory: one write port, one read port with registered data.
module fer_store #(
	parameter int DEPTH = 27648,
	parameter int AW    = 15
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);

	logic [7:0] mem [DEPTH];

	// store a recorded byte
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// fetch a playback byte
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/fer_play.sv =====
// Playback streamer: walks one frame through the memory read port.
module fer_play #(
	parameter int FRAME_BYTES = 54,
	parameter int AW          = 15
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          go,
	input  logic [AW-1:0] base,
	output logic          rd_en,
	output logic [AW-1:0] rd_addr,
	output logic          busy,
	output logic          vld,
	output logic          last
);

	localparam int BW = $clog2(FRAME_BYTES + 1);

	logic          active_q;
	logic [AW-1:0] addr_q;
	logic [BW-1:0] cnt_q;
	logic          vld_s1;
	logic          last_s1;
	logic          cnt_end;

	assign cnt_end = (cnt_q == BW'(FRAME_BYTES - 1));
	assign rd_en   = active_q;
	assign rd_addr = addr_q;
	assign busy    = active_q;
	assign vld     = vld_s1;
	assign last    = last_s1;

	// advance the read address once per cycle until the frame is issued
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q    <= '0;
			vld_s1   <= 1'b0;
			last_s1  <= 1'b0;
		end else begin
			vld_s1  <= active_q;
			last_s1 <= active_q && cnt_end;
			if (go) begin
				active_q <= 1'b1;
				cnt_q    <= '0;
			end else if (active_q) begin
				if (cnt_end) begin
					active_q <= 1'b0;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// hold the byte address
	always_ff @(posedge clk) begin
		if (go) begin
			addr_q <= base;
		end else if (active_q) begin
			addr_q <= addr_q + 1'b1;
		end
	end

endmodule

// ===== rtl/fer_ctrl.sv =====
// Request decoder and recorder state: record, delay timer, pacing, clear.
module fer_ctrl #(
	parameter int FRAME_BYTES = 54,
	parameter int MAX_FRAMES  = 512,
	parameter int AW          = 15
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  fer_pkg::req_t    req,
	input  logic [9:0]       capacity,
	input  logic [15:0]      delay,
	input  logic [7:0]       period,
	output logic             result_valid,
	output fer_pkg::result_t result,
	output logic             wr_en,
	output logic [AW-1:0]    wr_addr,
	output logic [7:0]       wr_data,
	output logic             go,
	output logic [AW-1:0]    base
);

	localparam int UW = $clog2(MAX_FRAMES + 1);
	localparam int BW = $clog2(FRAME_BYTES + 1);
	localparam int CW = ((UW > 10) ? UW : 10) + 1;
	localparam int PW = UW + 9;

	logic [UW-1:0] used_q, used_n;
	logic [UW-1:0] sent_q, sent_n;
	logic [BW-1:0] idx_q, idx_n;
	logic          fits_q, fits_n;
	logic [1:0]    mode_q, mode_n;
	logic [15:0]   delay_q, delay_n;
	logic          running_q, running_n;
	logic [31:0]   play_q, play_n;

	logic [CW-1:0] cap_ext;
	logic [CW-1:0] cap_eff;
	logic          fits_now;
	logic          idx_last;
	logic [32:0]   play_sum;
	logic [31:0]   play_sat;
	logic [16:0]   dly_sum;
	logic [15:0]   dly_sat;
	logic [7:0]    period_eff;
	logic [UW:0]   sent_inc;
	logic [PW-1:0] pace;
	logic          pace_wait;
	logic          sent_done;
	logic [2:0]    kind;

	// clamp capacity to the store size
	assign cap_ext  = CW'(capacity);
	assign cap_eff  = (cap_ext > CW'(MAX_FRAMES)) ? CW'(MAX_FRAMES) : cap_ext;
	assign fits_now = (idx_q == '0) ? (CW'(used_q) < cap_eff) : fits_q;
	assign idx_last = (idx_q == BW'(FRAME_BYTES - 1));

	// saturating timer sums
	assign play_sum = {1'b0, play_q} + 33'(req.tick_ms);
	assign play_sat = play_sum[32] ? 32'hFFFF_FFFF : play_sum[31:0];
	assign dly_sum  = {1'b0, delay_q} + 17'(req.tick_ms);
	assign dly_sat  = dly_sum[16] ? 16'hFFFF : dly_sum[15:0];

	// pacing: frame not yet due while elapsed < (sent + 1) * period
	assign period_eff = (period == 8'd0) ? 8'd1 : period;
	assign sent_inc   = {1'b0, sent_q} + 1'b1;
	assign pace       = PW'(sent_inc) * PW'(period_eff);
	assign pace_wait  = play_q < 32'(pace);
	assign sent_done  = (sent_q >= used_q) || (CW'(sent_q) >= CW'(MAX_FRAMES));

	assign wr_addr = AW'(32'(used_q) * FRAME_BYTES + 32'(idx_q));
	assign wr_data = req.data_byte;
	assign base    = AW'(32'(sent_q) * FRAME_BYTES);

	// decode one request into the next state
	always_comb begin
		used_n    = used_q;
		sent_n    = sent_q;
		idx_n     = idx_q;
		fits_n    = fits_q;
		mode_n    = mode_q;
		delay_n   = delay_q;
		running_n = running_q;
		play_n    = play_q;
		kind      = fer_pkg::KIND_NONE;
		wr_en     = 1'b0;
		go        = 1'b0;
		if (accept) begin
			case (req.func)
				fer_pkg::FUNC_WRITE: begin
					fits_n = fits_now;
					wr_en  = fits_now;
					if (idx_last) begin
						idx_n = '0;
						if (fits_now) begin
							used_n = used_q + 1'b1;
							mode_n = fer_pkg::MODE_REC;
							kind   = fer_pkg::KIND_STORED;
						end else begin
							kind = fer_pkg::KIND_REJECT;
						end
					end else begin
						idx_n = idx_q + 1'b1;
					end
				end
				fer_pkg::FUNC_END: begin
					sent_n    = '0;
					mode_n    = fer_pkg::MODE_WAIT;
					delay_n   = '0;
					running_n = 1'b1;
				end
				fer_pkg::FUNC_CLEAR: begin
					used_n    = '0;
					sent_n    = '0;
					idx_n     = '0;
					fits_n    = 1'b0;
					mode_n    = fer_pkg::MODE_IDLE;
					delay_n   = '0;
					running_n = 1'b0;
					play_n    = '0;
				end
				fer_pkg::FUNC_TICK: begin
					if (mode_q == fer_pkg::MODE_PLAY) begin
						play_n = play_sat;
					end
					if (running_q) begin
						delay_n = dly_sat;
						if (dly_sat >= delay) begin
							running_n = 1'b0;
							mode_n    = fer_pkg::MODE_PLAY;
							sent_n    = '0;
							play_n    = '0;
						end
					end
				end
				fer_pkg::FUNC_READ: begin
					if (mode_q != fer_pkg::MODE_PLAY) begin
						kind = fer_pkg::KIND_NONE;
					end else if (used_q == '0) begin
						mode_n = fer_pkg::MODE_IDLE;
						kind   = fer_pkg::KIND_END;
					end else if (pace_wait) begin
						kind = fer_pkg::KIND_NONE;
					end else if (sent_done) begin
						used_n = '0;
						mode_n = fer_pkg::MODE_IDLE;
						kind   = fer_pkg::KIND_END;
					end else begin
						go     = 1'b1;
						sent_n = sent_q + 1'b1;
					end
				end
				default: begin
					kind = fer_pkg::KIND_NONE;
				end
			endcase
		end
	end

	// hold recorder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q       <= '0;
			sent_q       <= '0;
			idx_q        <= '0;
			fits_q       <= 1'b0;
			mode_q       <= fer_pkg::MODE_IDLE;
			delay_q      <= '0;
			running_q    <= 1'b0;
			play_q       <= '0;
			result_valid <= 1'b0;
		end else begin
			used_q       <= used_n;
			sent_q       <= sent_n;
			idx_q        <= idx_n;
			fits_q       <= fits_n;
			mode_q       <= mode_n;
			delay_q      <= delay_n;
			running_q    <= running_n;
			play_q       <= play_n;
			result_valid <= accept && !go;
		end
	end

	// register the single result of a non-streaming request
	always_ff @(posedge clk) begin
		if (accept) begin
			result.kind     <= kind;
			result.out_byte <= 8'd0;
			result.last     <= 1'b1;
			result.mode     <= mode_n;
		end
	end

endmodule

// ===== rtl/frame_echo_record_replay_top.sv =====
// Frame echo recorder top level: register port, control, streamer, frame memory.
// A request that plays no frame gives its single result in the cycle after it is taken.
// A read that plays a frame streams its FRAME_BYTES bytes via the streamer's active flag,
// the registered memory read data and the valid stage, one byte per cycle; busy is high
// while the streamer issues the frame's reads, and no request is taken while busy is high.
// Other requests are taken every cycle. The receiver cannot stall results.
// Reset clears all control state and returns the registers to their defaults;
// frame memory contents stay undefined.
module frame_echo_record_replay_top #(
	parameter int FRAME_BYTES = 54,
	parameter int MAX_FRAMES  = 512
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  fer_pkg::req_t    req,
	output logic             result_valid,
	output fer_pkg::result_t result,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [3:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int DEPTH = FRAME_BYTES * MAX_FRAMES;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [9:0]       capacity_q;
	logic [15:0]      delay_q;
	logic [7:0]       period_q;
	logic             cfg_wr;
	logic             accept;
	logic             ctrl_valid;
	fer_pkg::result_t ctrl_result;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [7:0]       wr_data;
	logic             go;
	logic [AW-1:0]    base;
	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	logic [7:0]       rd_data;
	logic             play_vld;
	logic             play_last;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign accept = start && !busy;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= fer_pkg::CAPACITY_RST;
			delay_q    <= fer_pkg::DELAY_RST;
			period_q   <= fer_pkg::PERIOD_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				fer_pkg::REG_CAPACITY: capacity_q <= pwdata[9:0];
				fer_pkg::REG_DELAY:    delay_q    <= pwdata[15:0];
				fer_pkg::REG_PERIOD:   period_q   <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// read back configuration registers
	always_comb begin
		case (paddr[3:2])
			fer_pkg::REG_CAPACITY: prdata = 32'(capacity_q);
			fer_pkg::REG_DELAY:    prdata = 32'(delay_q);
			fer_pkg::REG_PERIOD:   prdata = 32'(period_q);
			default:               prdata = 32'd0;
		endcase
	end

	fer_ctrl #(
		.FRAME_BYTES(FRAME_BYTES),
		.MAX_FRAMES (MAX_FRAMES),
		.AW         (AW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.req         (req),
		.capacity    (capacity_q),
		.delay       (delay_q),
		.period      (period_q),
		.result_valid(ctrl_valid),
		.result      (ctrl_result),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.go          (go),
		.base        (base)
	);

	fer_play #(
		.FRAME_BYTES(FRAME_BYTES),
		.AW         (AW)
	) u_play (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.base   (base),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.busy   (busy),
		.vld    (play_vld),
		.last   (play_last)
	);

	fer_store #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// merge streamed bytes with single results
	assign result_valid = play_vld || ctrl_valid;
	always_comb begin
		if (play_vld) begin
			result.kind     = fer_pkg::KIND_DATA;
			result.out_byte = rd_data;
			result.last     = play_last;
			result.mode     = fer_pkg::MODE_PLAY;
		end else begin
			result = ctrl_result;
		end
	end

	// streamed bytes and single results never collide
	a_no_collide: assert property (@(posedge clk) disable iff (!arst_n)
		!(play_vld && ctrl_valid))
		else $error("stream byte and single result in the same cycle");

	// a taken request shows a result or starts streaming in the next cycle
	a_req_answer: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (result_valid || busy))
		else $error("request left without result");

	// the frame's final byte follows the end of the read issue
	a_stream_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> (play_vld && play_last))
		else $error("stream ended without last byte");

	// data bytes only come out while playing
	a_data_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.kind == fer_pkg::KIND_DATA) |-> result.mode == fer_pkg::MODE_PLAY)
		else $error("data byte outside playback");

endmodule

// ===== tb/frame_echo_record_replay_top_tb.sv =====
// Testbench for the frame echo recorder: echo scoreboard class plus request and register drivers.
module frame_echo_record_replay_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fer_pkg::*;

	localparam int FRAME_BYTES = 54;
	localparam int MAX_FRAMES  = 512;
	localparam int STORE_BYTES = FRAME_BYTES * MAX_FRAMES;
	localparam int QUIET_AFTER = 340;

	// Mirror of the recorder: works out the results each request must produce.
	class echo_scoreboard;
		logic [7:0]  frame_mem [STORE_BYTES];
		int unsigned used_frames, sent_frames, byte_idx, delay_count;
		bit          fits, delay_on;
		logic [1:0]  mode;
		logic [31:0] play_ms;
		int unsigned capacity, delay_set, period;
		result_t     echo_results [$];
		int unsigned errors, requests, results_seen, frames_played, frames_rejected;

		function new();
			capacity  = 32'(CAPACITY_RST);
			delay_set = 32'(DELAY_RST);
			period    = 32'(PERIOD_RST);
			clear_all();
		endfunction

		function void clear_all();
			used_frames = 0;
			sent_frames = 0;
			byte_idx    = 0;
			fits        = 1'b0;
			mode        = MODE_IDLE;
			delay_count = 0;
			delay_on    = 1'b0;
			play_ms     = '0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [31:0] value);
			case (idx)
				REG_CAPACITY: capacity = 32'(value[9:0]);
				REG_DELAY:    delay_set = 32'(value[15:0]);
				REG_PERIOD:   period = 32'(value[7:0]);
				default: ;
			endcase
		endfunction

		// Queue one result; mode is taken after the request has been applied.
		function void push(logic [2:0] kind, logic [7:0] b, logic last);
			result_t r;
			r.kind     = kind;
			r.out_byte = b;
			r.last     = last;
			r.mode     = mode;
			echo_results.push_back(r);
		endfunction

		function void record_request(req_t r);
			int unsigned cap, per, wanted, base;
			logic [32:0] sum;
			int k;
			requests++;
			case (r.func)
				FUNC_WRITE: begin
					cap = capacity > MAX_FRAMES ? MAX_FRAMES : capacity;
					// decide at the first byte whether the frame is kept
					if (byte_idx == 0)
						fits = used_frames < cap;
					if (fits)
						frame_mem[used_frames * FRAME_BYTES + byte_idx] = r.data_byte;
					byte_idx++;
					if (byte_idx >= FRAME_BYTES) begin
						byte_idx = 0;
						if (fits) begin
							used_frames++;
							mode = MODE_REC;
							push(KIND_STORED, 8'h00, 1'b1);
						end else begin
							frames_rejected++;
							push(KIND_REJECT, 8'h00, 1'b1);
						end
					end else begin
						push(KIND_NONE, 8'h00, 1'b1);
					end
				end
				FUNC_END: begin
					sent_frames = 0;
					mode        = MODE_WAIT;
					delay_count = 0;
					delay_on    = 1'b1;
					push(KIND_NONE, 8'h00, 1'b1);
				end
				FUNC_CLEAR: begin
					clear_all();
					push(KIND_NONE, 8'h00, 1'b1);
				end
				FUNC_TICK: begin
					// advance the playback clock, saturating
					if (mode == MODE_PLAY) begin
						sum = {1'b0, play_ms} + r.tick_ms;
						play_ms = sum[32] ? '1 : sum[31:0];
					end
					// advance the delay timer, start playback on expiry
					if (delay_on) begin
						delay_count = delay_count + r.tick_ms;
						if (delay_count > 65535)
							delay_count = 65535;
						if (delay_count >= delay_set) begin
							delay_on    = 1'b0;
							mode        = MODE_PLAY;
							sent_frames = 0;
							play_ms     = '0;
						end
					end
					push(KIND_NONE, 8'h00, 1'b1);
				end
				FUNC_READ: begin
					if (mode != MODE_PLAY) begin
						push(KIND_NONE, 8'h00, 1'b1);
					end else if (used_frames == 0) begin
						mode = MODE_IDLE;
						push(KIND_END, 8'h00, 1'b1);
					end else begin
						per    = period == 0 ? 1 : period;
						wanted = play_ms / per;
						if (sent_frames >= wanted) begin
							push(KIND_NONE, 8'h00, 1'b1);
						end else if (sent_frames >= used_frames || sent_frames >= MAX_FRAMES) begin
							used_frames = 0;
							mode        = MODE_IDLE;
							push(KIND_END, 8'h00, 1'b1);
						end else begin
							base = sent_frames * FRAME_BYTES;
							for (k = 0; k < FRAME_BYTES; k++)
								push(KIND_DATA, frame_mem[base + k], k == FRAME_BYTES - 1);
							sent_frames++;
							frames_played++;
						end
					end
				end
				default: push(KIND_NONE, 8'h00, 1'b1);
			endcase
		endfunction

		function void check_result(result_t got);
			result_t want;
			results_seen++;
			if (echo_results.size() == 0) begin
				$error("result with nothing pending: kind %0d out_byte %0h", got.kind, got.out_byte);
				errors++;
				return;
			end
			want = echo_results.pop_front();
			if (got.kind !== want.kind) begin
				$error("kind: expected %0d, got %0d", want.kind, got.kind);
				errors++;
			end
			if (got.out_byte !== want.out_byte) begin
				$error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0b, got %0b", want.last, got.last);
				errors++;
			end
			if (got.mode !== want.mode) begin
				$error("mode: expected %0d, got %0d", want.mode, got.mode);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	req_t        req;
	logic        result_valid;
	result_t     result;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	echo_scoreboard sb;
	int unsigned    sent_count;
	bit             gaps_on;

	frame_echo_record_replay_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req          (req),
		.result_valid (result_valid),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Check results before noting the request taken at the same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid)
				sb.check_result(result);
			if (start && !busy)
				sb.record_request(req);
		end
	end

	// Present one request at a falling edge, hold it until taken, then maybe pause.
	task automatic send_request(logic [2:0] f, logic [7:0] d, logic [15:0] ms);
		start         = 1'b1;
		req.func      = f;
		req.data_byte = d;
		req.tick_ms   = ms;
		do @(posedge clk); while (busy);
		@(negedge clk);
		sent_count++;
		if (gaps_on && sent_count < QUIET_AFTER && $urandom_range(0, 3) == 0) begin
			start = 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
	endtask

	// Write a register field with random upper bits, then read it back.
	task automatic cfg_write(logic [1:0] idx, logic [31:0] field);
		logic [31:0] mask, value;
		mask  = idx == REG_CAPACITY ? 32'h3ff : (idx == REG_DELAY ? 32'hffff : 32'hff);
		value = ($urandom & ~mask) | (field & mask);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_reg(idx, value);
		@(negedge clk);
		penable = 1'b0;
		pwrite  = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== (value & mask)) begin
			$error("prdata: expected %0h, got %0h", value & mask, prdata);
			sb.errors++;
		end
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	// Drop start and wait until every pending result has come out.
	task automatic wait_drained();
		start = 1'b0;
		while (sb.echo_results.size() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		int unsigned nframes, tries, b;
		logic [2:0]  f;
		sb         = new();
		sent_count = 0;
		gaps_on    = 1'b1;
		arst_n     = 1'b0;
		start      = 1'b0;
		req        = '0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: idle requests, a partial frame, delay expiry, empty playback.
		send_request(FUNC_READ, 8'h00, 16'h0000);
		send_request(FUNC_TICK, 8'h00, 16'hffff);
		send_request(FUNC_WRITE, 8'h00, 16'h0000);
		send_request(FUNC_WRITE, 8'hff, 16'hffff);
		send_request(FUNC_END, 8'h00, 16'h0000);
		send_request(FUNC_TICK, 8'h00, 16'h0000);
		send_request(FUNC_TICK, 8'h00, 16'hffff);
		send_request(FUNC_TICK, 8'h00, 16'hffff);
		send_request(FUNC_READ, 8'h00, 16'h0000);
		for (f = FUNC_READ + 3'd1; f != FUNC_WRITE; f++)
			send_request(f, 8'h55 ^ {5'd0, f}, 16'haaaa);
		send_request(FUNC_CLEAR, 8'h00, 16'h0000);
		wait_drained();

		// Zero delay, zero capacity, zero period.
		cfg_write(REG_DELAY, 32'd0);
		cfg_write(REG_CAPACITY, 32'd0);
		cfg_write(REG_PERIOD, 32'd0);
		send_request(FUNC_END, 8'h00, 16'h0000);
		send_request(FUNC_TICK, 8'h00, 16'h0000);
		send_request(FUNC_READ, 8'h00, 16'h0000);
		send_request(FUNC_CLEAR, 8'h00, 16'h0000);

		// Random sessions: record, end, wait out the delay, play back.
		while (sent_count < 400) begin
			wait_drained();
			gaps_on = $urandom_range(0, 3) != 0;
			case ($urandom_range(0, 5))
				0: cfg_write(REG_CAPACITY, 32'd0);
				1: cfg_write(REG_CAPACITY, 32'd1);
				2: cfg_write(REG_CAPACITY, 32'd2);
				3: cfg_write(REG_CAPACITY, 32'd1023);
				4: cfg_write(REG_CAPACITY, MAX_FRAMES);
				default: cfg_write(REG_CAPACITY, $urandom_range(3, 600));
			endcase
			case ($urandom_range(0, 4))
				0: cfg_write(REG_DELAY, 32'd0);
				1: cfg_write(REG_DELAY, 32'd1);
				2: cfg_write(REG_DELAY, 32'd65535);
				default: cfg_write(REG_DELAY, $urandom_range(2, 300));
			endcase
			case ($urandom_range(0, 4))
				0: cfg_write(REG_PERIOD, 32'd0);
				1: cfg_write(REG_PERIOD, 32'd1);
				2: cfg_write(REG_PERIOD, 32'd255);
				default: cfg_write(REG_PERIOD, $urandom_range(2, 60));
			endcase

			if ($urandom_range(0, 3) == 0)
				send_request(FUNC_CLEAR, 8'($urandom), 16'($urandom));

			// record whole frames, with the odd stray request mixed in
			nframes = $urandom_range(0, 3);
			repeat (nframes) begin
				for (b = 0; b < FRAME_BYTES; b++) begin
					if ($urandom_range(0, 39) == 0)
						send_request(3'($urandom_range(0, 7)), 8'($urandom), 16'($urandom));
					send_request(FUNC_WRITE, 8'($urandom), 16'($urandom));
				end
			end
			// leave a partial frame behind now and then
			if ($urandom_range(0, 4) == 0)
				repeat ($urandom_range(1, 20))
					send_request(FUNC_WRITE, 8'($urandom), 16'($urandom));
			if ($urandom_range(0, 7) != 0)
				send_request(FUNC_END, 8'($urandom), 16'($urandom));

			// run the delay timer out
			tries = 0;
			while (sb.delay_on && tries < 12) begin
				send_request(FUNC_TICK, 8'($urandom),
					tries >= 8 ? 16'hffff : 16'($urandom_range(0, sb.delay_set / 3 + 1)));
				tries++;
			end

			// play back: reads paced by ticks until the end is signaled
			tries = 0;
			while (sb.mode == MODE_PLAY && tries < 60) begin
				if ($urandom_range(0, 29) == 0)
					send_request(3'($urandom_range(0, 7)), 8'($urandom), 16'($urandom));
				else if ($urandom_range(0, 9) < 6)
					send_request(FUNC_READ, 8'($urandom), 16'($urandom));
				else
					send_request(FUNC_TICK, 8'($urandom),
						16'($urandom_range(0, 3 * sb.period + 3)));
				tries++;
			end
		end

		start = 1'b0;
		while (sb.echo_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		$display("Ran %0d requests through record, delay and playback; checked %0d results.",
			sb.requests, sb.results_seen);
		$display("Frames replayed: %0d, frames rejected: %0d.", sb.frames_played,
			sb.frames_rejected);
		if (sb.errors == 0)
			$display("frame_echo_record_replay_top_tb: PASS");
		else
			$display("frame_echo_record_replay_top_tb: FAIL");
		$finish;
	end

	// Stop a hung run.
	initial begin
		#5_000_000;
		$display("frame_echo_record_replay_top_tb: FAIL");
		$finish;
	end

endmodule
